// File: rtl/sccti_pkg.sv
// Shared constants and ROM-building functions for the sine/cosine table interpolator.
package sccti_pkg;

  localparam int DEFAULT_TABLE_DEPTH   = 512;
  localparam int DEFAULT_FRACTION_BITS = 16;
  localparam int ANGLE_W               = 32;
  localparam int SAMPLE_W              = 16;

  localparam logic [63:0] PI_Q60  = 64'h3243F6A8885A308D;
  localparam logic [63:0] ONE_Q60 = 64'h1000000000000000;
  localparam logic [63:0] Q15_MAX = 64'd32767;

  // (a*b) >> 60 on a full-width product
  function automatic logic [63:0] mul_q60(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  // unsigned long division by shift and subtract; only evaluated while building the ROM
  function automatic logic [63:0] div_u64(logic [63:0] num, logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] part;
    quo  = '0;
    part = '0;
    for (int b = 63; b >= 0; b--) begin
      part = {part[63:0], num[b]};
      if (part >= {1'b0, den}) begin
        part   = part - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // round(32768*sin(2*pi*idx/depth)) clamped to +32767; depth is a power of two
  function automatic logic signed [SAMPLE_W-1:0] rom_entry(int unsigned idx,
                                                           int unsigned depth);
    logic [63:0] n;
    logic [63:0] num;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] mag;
    logic [63:0] d1;
    logic        neg;
    logic        use_cos;
    int          sh;
    n       = 64'(depth);
    num     = 64'd8 * (64'(idx) & (n - 64'd1));
    neg     = 1'b0;
    use_cos = 1'b0;
    if (num >= 64'd4 * n) begin
      num = num - 64'd4 * n;
      neg = 1'b1;
    end
    if (num > 64'd2 * n) num = 64'd4 * n - num;
    if (num > n) begin
      num     = 64'd2 * n - num;
      use_cos = 1'b1;
    end
    sh   = $clog2(depth) + 2;
    x    = mul_q60(PI_Q60, ((num << 48) >> sh) << 12);
    x2   = mul_q60(x, x);
    term = use_cos ? ONE_Q60 : x;
    sum  = term;
    for (int k = 1; k <= 14; k++) begin
      d1   = 64'(2 * k) - (use_cos ? 64'd1 : 64'd0);
      term = div_u64(mul_q60(term, x2), d1 * (d1 + 64'd1));
      if ((k & 1) == 1) sum = sum - term;
      else sum = sum + term;
    end
    mag = (sum + (64'd1 << 44)) >> 45;
    if (neg) return SAMPLE_W'(64'd0 - mag);
    if (mag > Q15_MAX) return SAMPLE_W'(Q15_MAX);
    return SAMPLE_W'(mag);
  endfunction

endpackage

// File: rtl/sine_cosine_table_interpolator_core.sv
// Top level of the table-based sine/cosine interpolator.
// out_valid is carried through the index, ROM, product and result registers
// alongside its item, so it rises with the matching sine and cosine results.
// Throughput: one item per cycle; busy stays low since results are never held off.
// Stages: index split, ROM read, difference multiply, round and add.
// Reset clears the valid pipeline; the ROM is constant and needs no fill.
module sine_cosine_table_interpolator_core #(
  parameter int TABLE_DEPTH   = sccti_pkg::DEFAULT_TABLE_DEPTH,
  parameter int FRACTION_BITS = sccti_pkg::DEFAULT_FRACTION_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [sccti_pkg::ANGLE_W-1:0] in_turn_angle,
  output logic                                 out_valid,
  output logic signed [sccti_pkg::SAMPLE_W-1:0] out_sine_value,
  output logic signed [sccti_pkg::SAMPLE_W-1:0] out_cosine_value
);
  import sccti_pkg::*;

  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int ADDR_W = IDX_W + 1;

  logic                     accept;
  logic [FRACTION_BITS-1:0] frac_s;
  logic [FRACTION_BITS-1:0] frac_c;

  logic                     s1_valid_r;
  logic [IDX_W-1:0]         s1_sin_idx_r;
  logic [IDX_W-1:0]         s1_cos_idx_r;
  logic [FRACTION_BITS-1:0] s1_sin_rem_r;
  logic [FRACTION_BITS-1:0] s1_cos_rem_r;

  logic                     s2_valid_r;
  logic [FRACTION_BITS-1:0] s2_sin_rem_r;
  logic [FRACTION_BITS-1:0] s2_cos_rem_r;

  logic                     s3_valid_r;
  logic                     out_valid_r;

  logic signed [SAMPLE_W-1:0] sin_lo;
  logic signed [SAMPLE_W-1:0] sin_hi;
  logic signed [SAMPLE_W-1:0] cos_lo;
  logic signed [SAMPLE_W-1:0] cos_hi;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // drop whole turns; cosine is a quarter turn ahead
  assign frac_s = in_turn_angle[FRACTION_BITS-1:0];
  assign frac_c = frac_s + (FRACTION_BITS'(1) << (FRACTION_BITS - 2));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= accept;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      out_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_sin_idx_r <= IDX_W'(frac_s >> (FRACTION_BITS - IDX_W));
    s1_cos_idx_r <= IDX_W'(frac_c >> (FRACTION_BITS - IDX_W));
    s1_sin_rem_r <= frac_s << IDX_W;
    s1_cos_rem_r <= frac_c << IDX_W;
    s2_sin_rem_r <= s1_sin_rem_r;
    s2_cos_rem_r <= s1_cos_rem_r;
  end

  sccti_rom #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ADDR_W      (ADDR_W)
  ) u_sin_rom (
    .clk       (clk),
    .rd_addr_a (ADDR_W'(s1_sin_idx_r)),
    .rd_addr_b (ADDR_W'(s1_sin_idx_r) + ADDR_W'(1)),
    .rd_data_a (sin_lo),
    .rd_data_b (sin_hi)
  );

  sccti_rom #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ADDR_W      (ADDR_W)
  ) u_cos_rom (
    .clk       (clk),
    .rd_addr_a (ADDR_W'(s1_cos_idx_r)),
    .rd_addr_b (ADDR_W'(s1_cos_idx_r) + ADDR_W'(1)),
    .rd_data_a (cos_lo),
    .rd_data_b (cos_hi)
  );

  sccti_interp #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_sin_interp (
    .clk    (clk),
    .lo_val (sin_lo),
    .hi_val (sin_hi),
    .rem    (s2_sin_rem_r),
    .result (out_sine_value)
  );

  sccti_interp #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_cos_interp (
    .clk    (clk),
    .lo_val (cos_lo),
    .hi_val (cos_hi),
    .rem    (s2_cos_rem_r),
    .result (out_cosine_value)
  );

  assign out_valid = out_valid_r;

endmodule

// File: rtl/sccti_rom.sv
// Full-period sine ROM with two registered read ports.
module sccti_rom #(
  parameter int TABLE_DEPTH = sccti_pkg::DEFAULT_TABLE_DEPTH,
  parameter int ADDR_W      = $clog2(TABLE_DEPTH) + 1
) (
  input  logic                                 clk,
  input  logic [ADDR_W-1:0]                    rd_addr_a,
  input  logic [ADDR_W-1:0]                    rd_addr_b,
  output logic signed [sccti_pkg::SAMPLE_W-1:0] rd_data_a,
  output logic signed [sccti_pkg::SAMPLE_W-1:0] rd_data_b
);
  import sccti_pkg::*;

  typedef logic signed [SAMPLE_W-1:0] rom_arr_t [0:TABLE_DEPTH];

  function automatic rom_arr_t build_rom();
    rom_arr_t t;
    for (int i = 0; i <= TABLE_DEPTH; i++) t[i] = rom_entry(i, TABLE_DEPTH);
    return t;
  endfunction

  localparam rom_arr_t ROM = build_rom();

  logic signed [SAMPLE_W-1:0] rd_data_a_r;
  logic signed [SAMPLE_W-1:0] rd_data_b_r;

  always_ff @(posedge clk) begin
    rd_data_a_r <= ROM[rd_addr_a];
    rd_data_b_r <= ROM[rd_addr_b];
  end

  assign rd_data_a = rd_data_a_r;
  assign rd_data_b = rd_data_b_r;

endmodule

// File: rtl/sccti_interp.sv
// Two-stage linear interpolation between neighboring ROM entries.
module sccti_interp #(
  parameter int FRACTION_BITS = sccti_pkg::DEFAULT_FRACTION_BITS
) (
  input  logic                                 clk,
  input  logic signed [sccti_pkg::SAMPLE_W-1:0] lo_val,
  input  logic signed [sccti_pkg::SAMPLE_W-1:0] hi_val,
  input  logic [FRACTION_BITS-1:0]             rem,
  output logic signed [sccti_pkg::SAMPLE_W-1:0] result
);
  import sccti_pkg::*;

  localparam int DIFF_W = SAMPLE_W + 1;
  localparam int PROD_W = DIFF_W + FRACTION_BITS + 1;
  localparam int QUO_W  = PROD_W - FRACTION_BITS;

  logic signed [DIFF_W-1:0]   diff;
  logic signed [PROD_W-1:0]   prod_nxt;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [SAMPLE_W-1:0] base_r;
  logic signed [PROD_W-1:0]   rounded;
  logic signed [QUO_W-1:0]    quo;
  logic signed [QUO_W-1:0]    sum_nxt;
  logic signed [SAMPLE_W-1:0] result_r;

  // m + (n-m)*r/S, rounded half up
  assign diff     = DIFF_W'(hi_val) - DIFF_W'(lo_val);
  assign prod_nxt = PROD_W'(diff) * $signed({1'b0, rem});

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    base_r <= lo_val;
  end

  assign rounded = prod_r + (PROD_W'(1) <<< (FRACTION_BITS - 1));
  assign quo     = QUO_W'(rounded >>> FRACTION_BITS);
  assign sum_nxt = QUO_W'(base_r) + quo;

  always_ff @(posedge clk) begin
    result_r <= SAMPLE_W'(sum_nxt);
  end

  assign result = result_r;

endmodule

// File: rtl/sccti_checker.sv
// Port-level checks for the sine/cosine interpolator, bound to the top level.
module sccti_checker #(
  parameter int FRACTION_BITS = sccti_pkg::DEFAULT_FRACTION_BITS
) (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 start,
  input logic                                 busy,
  input logic signed [sccti_pkg::ANGLE_W-1:0] in_turn_angle,
  input logic                                 out_valid,
  input logic signed [sccti_pkg::SAMPLE_W-1:0] out_sine_value,
  input logic signed [sccti_pkg::SAMPLE_W-1:0] out_cosine_value
);
  import sccti_pkg::*;

  localparam int LATENCY = 4;

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_item_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("item produced no result");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result without item");

  a_zero_angle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_turn_angle[FRACTION_BITS-1:0] == '0) |-> ##LATENCY
    (out_sine_value == 16'sd0 && out_cosine_value == 16'sd32767))
    else $error("wrong result at zero angle");

endmodule

bind sine_cosine_table_interpolator_core sccti_checker #(
  .FRACTION_BITS (FRACTION_BITS)
) u_sccti_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_turn_angle    (in_turn_angle),
  .out_valid        (out_valid),
  .out_sine_value   (out_sine_value),
  .out_cosine_value (out_cosine_value)
);
